// ===== src/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared constants, register indexes and the command and status types that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int unsigned RADIUS_BITS_DEF = 10;
  localparam int unsigned COORD_BITS_DEF  = 12;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

  localparam int unsigned RADIUS_X_RST = 5;
  localparam int unsigned RADIUS_Y_RST = 10;

  // Datapath micro-operations, one per clock cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_RS1, OP_RS2, OP_RS3, OP_RS4,
    OP_R1A, OP_R1B, OP_R1C,
    OP_RCA, OP_RCB, OP_RCC, OP_RCD, OP_RCE, OP_RCF,
    OP_R2A, OP_R2B, OP_R2C,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic zero;  // with OP_OUT: result carries no points
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic region_two;
    logic slope_neg;
  } status_t;

endpackage

// ===== src/midpoint_ellipse_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Walks the first quadrant of an axis-aligned ellipse and emits the four
// mirror points of each step around the configured centre.
// ----------------------------------------------------------------------------
// One input transaction is handled at a time, and each yields exactly one
// result. A step in region one or region two, a restart, the step that
// crosses into region two and a tick after the walk has ended each run their
// own sequence of micro-operations. The single shared multiplier produces
// one registered product per cycle and is used two to seven times per step.
// A finished result waits in the output register while the next transaction
// is already being worked on. Radii are squared and latched at a restart;
// the centre is applied to every step.
module midpoint_ellipse_rasterizer_top #(
  parameter int unsigned RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int unsigned COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write port
  input  logic                                    cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] cfg_data_i,
  // Input stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [7:0]                              s_axis_tdata,  // restart
  // Output stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
  output logic [8*(COORD_BITS+1)-1:0]             m_axis_tdata,
  output logic                                    m_axis_tlast,  // last
  output logic                                    m_axis_tuser   // valid_res
);

  localparam int unsigned CFG_W   = (RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS;
  localparam int unsigned TDATA_W = 8 * (COORD_BITS + 1);

  mer_pkg::cmd_t    cmd;
  mer_pkg::status_t status;

  mer_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tdata[0]),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .CFG_W       (CFG_W),
    .TDATA_W     (TDATA_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_tdata_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== src/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences the datapath micro-operations for one input transaction and owns
// the handshake on both stream interfaces.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_restart_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mer_pkg::status_t status_i,
  output mer_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RS1, ST_RS2, ST_RS3, ST_RS4,
    ST_R1A, ST_R1B, ST_R1C,
    ST_RCA, ST_RCB, ST_RCC, ST_RCD, ST_RCE, ST_RCF,
    ST_R2A, ST_R2B, ST_R2C,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   zero_q, zero_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = mer_pkg::OP_NONE;
    cmd_o.zero  = zero_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          zero_d = 1'b0;
          if (in_restart_i) begin
            state_d = ST_RS1;
          end else if (status_i.finished) begin
            zero_d  = 1'b1;
            state_d = ST_OUT;
          end else if (status_i.region_two) begin
            state_d = ST_R2A;
          end else if (status_i.slope_neg) begin
            state_d = ST_R1A;
          end else begin
            state_d = ST_RCA;
          end
        end
      end
      ST_RS1: begin cmd_o.op = mer_pkg::OP_RS1; state_d = ST_RS2; end
      ST_RS2: begin cmd_o.op = mer_pkg::OP_RS2; state_d = ST_RS3; end
      ST_RS3: begin cmd_o.op = mer_pkg::OP_RS3; state_d = ST_RS4; end
      ST_RS4: begin cmd_o.op = mer_pkg::OP_RS4; state_d = ST_OUT; end
      ST_R1A: begin cmd_o.op = mer_pkg::OP_R1A; state_d = ST_R1B; end
      ST_R1B: begin cmd_o.op = mer_pkg::OP_R1B; state_d = ST_R1C; end
      ST_R1C: begin cmd_o.op = mer_pkg::OP_R1C; state_d = ST_OUT; end
      ST_RCA: begin cmd_o.op = mer_pkg::OP_RCA; state_d = ST_RCB; end
      ST_RCB: begin cmd_o.op = mer_pkg::OP_RCB; state_d = ST_RCC; end
      ST_RCC: begin cmd_o.op = mer_pkg::OP_RCC; state_d = ST_RCD; end
      ST_RCD: begin cmd_o.op = mer_pkg::OP_RCD; state_d = ST_RCE; end
      ST_RCE: begin cmd_o.op = mer_pkg::OP_RCE; state_d = ST_RCF; end
      ST_RCF: begin cmd_o.op = mer_pkg::OP_RCF; state_d = ST_R2A; end
      ST_R2A: begin cmd_o.op = mer_pkg::OP_R2A; state_d = ST_R2B; end
      ST_R2B: begin cmd_o.op = mer_pkg::OP_R2B; state_d = ST_R2C; end
      ST_R2C: begin cmd_o.op = mer_pkg::OP_R2C; state_d = ST_OUT; end
      ST_OUT: begin
        // The result register is loaded only once the previous result has gone.
        if (out_free) begin
          cmd_o.op    = mer_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/mer_datapath.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Configuration registers, walk state, one shared multiplier with a registered
// product, the decision and slope adders and the result register.
// ----------------------------------------------------------------------------
module mer_datapath #(
  parameter int unsigned RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int unsigned COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int unsigned CFG_W       = (RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS,
  parameter int unsigned TDATA_W     = 8 * (COORD_BITS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  mer_pkg::cmd_t                  cmd_i,
  output mer_pkg::status_t               status_o,
  output logic [TDATA_W-1:0]             out_tdata_o,
  output logic                           out_last_o,
  output logic                           out_user_o
);

  localparam int unsigned R       = RADIUS_BITS;
  localparam int unsigned C       = COORD_BITS;
  localparam int unsigned SQ_W    = 2 * R;
  localparam int unsigned MA_W    = 2 * R;
  localparam int unsigned MB_W    = 2 * R + 2;
  localparam int unsigned PROD_W  = MA_W + MB_W;
  localparam int unsigned DEC_W   = 4 * R + 8;
  localparam int unsigned SLOPE_W = 3 * R + 4;
  localparam int unsigned PT_W    = C + 1;
  localparam int unsigned EXT_W   = ((R > C) ? R : C) + 2;
  localparam logic [R-1:0] ONE_R  = 1;

  // Configuration
  logic [C-1:0] cx_q, cy_q;
  logic [R-1:0] rx_q, ry_q;

  // Walk state
  logic               finished_q, finished_d;
  logic               region_two_q, region_two_d;
  logic [R-1:0]       ox_q, ox_d, oy_q, oy_d;
  logic [SQ_W-1:0]    a2_q, a2_d, b2_q, b2_d;
  logic [DEC_W-1:0]   dec_q, dec_d, acc_q, acc_d;
  logic [SLOPE_W-1:0] slope_q, slope_d;
  logic [PROD_W-1:0]  prod_q, prod_d;

  // Result register
  logic [TDATA_W-1:0] tdata_q, tdata_d;
  logic               last_q, last_d, user_q, user_d;

  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [R:0]         t_val;
  logic [R-1:0]       u_val;
  logic [DEC_W-1:0]   p_x, a2_x, b2_x;
  logic [SLOPE_W-1:0] a2_s, b2_s;
  logic               dec_neg, dec_pos;
  logic [EXT_W-1:0]   cx_e, cy_e, ox_e, oy_e;
  logic [PT_W-1:0]    xp, xm, yp, ym;

  assign t_val   = {ox_q, 1'b1};
  assign u_val   = oy_q - ONE_R;
  assign p_x     = {{(DEC_W - PROD_W){1'b0}}, prod_q};
  assign a2_x    = {{(DEC_W - SQ_W){1'b0}}, a2_q};
  assign b2_x    = {{(DEC_W - SQ_W){1'b0}}, b2_q};
  assign a2_s    = {{(SLOPE_W - SQ_W){1'b0}}, a2_q};
  assign b2_s    = {{(SLOPE_W - SQ_W){1'b0}}, b2_q};
  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_q != '0);

  assign status_o.finished   = finished_q;
  assign status_o.region_two = region_two_q;
  assign status_o.slope_neg  = slope_q[SLOPE_W-1];

  // Mirror points, wrapped to the output width.
  assign cx_e = {{(EXT_W - C){cx_q[C-1]}}, cx_q};
  assign cy_e = {{(EXT_W - C){cy_q[C-1]}}, cy_q};
  assign ox_e = {{(EXT_W - R){1'b0}}, ox_q};
  assign oy_e = {{(EXT_W - R){1'b0}}, oy_q};
  always_comb begin
    logic [EXT_W-1:0] s_xp, s_xm, s_yp, s_ym;
    s_xp = cx_e + ox_e;
    s_xm = cx_e - ox_e;
    s_yp = cy_e + oy_e;
    s_ym = cy_e - oy_e;
    xp   = s_xp[PT_W-1:0];
    xm   = s_xm[PT_W-1:0];
    yp   = s_yp[PT_W-1:0];
    ym   = s_ym[PT_W-1:0];
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      mer_pkg::OP_RS1: begin
        mul_a = {{(MA_W - R){1'b0}}, rx_q};
        mul_b = {{(MB_W - R){1'b0}}, rx_q};
      end
      mer_pkg::OP_RS2: begin
        mul_a = {{(MA_W - R){1'b0}}, oy_q};
        mul_b = {{(MB_W - R){1'b0}}, oy_q};
      end
      mer_pkg::OP_RS3, mer_pkg::OP_R1B, mer_pkg::OP_R2A: begin
        mul_a = a2_q;
        mul_b = {{(MB_W - R){1'b0}}, oy_q};
      end
      mer_pkg::OP_R1A, mer_pkg::OP_R2B: begin
        mul_a = b2_q;
        mul_b = {{(MB_W - R){1'b0}}, ox_q};
      end
      mer_pkg::OP_RCA: begin
        mul_a = {{(MA_W - R - 1){1'b0}}, t_val};
        mul_b = {{(MB_W - R - 1){1'b0}}, t_val};
      end
      mer_pkg::OP_RCB: begin
        mul_a = b2_q;
        mul_b = prod_q[MB_W-1:0];
      end
      mer_pkg::OP_RCC: begin
        mul_a = {{(MA_W - R){1'b0}}, u_val};
        mul_b = {{(MB_W - R){1'b0}}, u_val};
      end
      mer_pkg::OP_RCD: begin
        mul_a = a2_q;
        mul_b = prod_q[MB_W-1:0];
      end
      mer_pkg::OP_RCE: begin
        mul_a = a2_q;
        mul_b = {2'b00, b2_q};
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Decision, slope and offset updates. The decision is kept at four times
  // its real value; all arithmetic wraps and only its top bit and whether it is zero are tested.
  always_comb begin
    finished_d   = finished_q;
    region_two_d = region_two_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    a2_d         = a2_q;
    b2_d         = b2_q;
    dec_d        = dec_q;
    acc_d        = acc_q;
    slope_d      = slope_q;
    tdata_d      = tdata_q;
    last_d       = last_q;
    user_d       = user_q;
    case (cmd_i.op)
      mer_pkg::OP_RS1: begin
        ox_d         = '0;
        oy_d         = ry_q;
        region_two_d = 1'b0;
      end
      mer_pkg::OP_RS2: a2_d = prod_q[SQ_W-1:0];
      mer_pkg::OP_RS3: b2_d = prod_q[SQ_W-1:0];
      mer_pkg::OP_RS4: begin
        slope_d = '0 - prod_q[SLOPE_W-1:0];
        dec_d   = (b2_x << 2) - (p_x << 2) + a2_x;
      end
      mer_pkg::OP_R1A: acc_d = (b2_x << 3) + (b2_x << 2) + (dec_neg ? '0 : (a2_x << 3));
      mer_pkg::OP_R1B: acc_d = acc_q + (p_x << 3);
      mer_pkg::OP_R1C: begin
        dec_d   = dec_q + acc_q - (dec_neg ? '0 : (p_x << 3));
        slope_d = slope_q + b2_s + (dec_neg ? '0 : a2_s);
        ox_d    = ox_q + ONE_R;
        if (!dec_neg) begin
          oy_d = oy_q - ONE_R;
        end
      end
      mer_pkg::OP_RCC: acc_d = p_x;
      mer_pkg::OP_RCE: acc_d = acc_q + (p_x << 2);
      mer_pkg::OP_RCF: begin
        dec_d        = acc_q - (p_x << 2);
        region_two_d = 1'b1;
      end
      mer_pkg::OP_R2A: acc_d = (a2_x << 3) + (a2_x << 2) + (dec_pos ? '0 : (b2_x << 3));
      mer_pkg::OP_R2B: acc_d = acc_q - (p_x << 3);
      mer_pkg::OP_R2C: begin
        dec_d = dec_q + acc_q + (dec_pos ? '0 : (p_x << 3));
        oy_d  = oy_q - ONE_R;
        if (!dec_pos) begin
          ox_d = ox_q + ONE_R;
        end
      end
      mer_pkg::OP_OUT: begin
        if (cmd_i.zero) begin
          tdata_d = '0;
          last_d  = 1'b0;
          user_d  = 1'b0;
        end else begin
          tdata_d    = {ym, xm, ym, xp, yp, xm, yp, xp};
          last_d     = (oy_q == '0);
          user_d     = 1'b1;
          finished_d = (oy_q == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q         <= '0;
      cy_q         <= '0;
      rx_q         <= RADIUS_BITS'(mer_pkg::RADIUS_X_RST);
      ry_q         <= RADIUS_BITS'(mer_pkg::RADIUS_Y_RST);
      finished_q   <= 1'b1;
      region_two_q <= 1'b0;
    end else begin
      finished_q   <= finished_d;
      region_two_q <= region_two_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mer_pkg::CFG_CENTER_X: cx_q <= cfg_data_i[C-1:0];
          mer_pkg::CFG_CENTER_Y: cy_q <= cfg_data_i[C-1:0];
          mer_pkg::CFG_RADIUS_X: rx_q <= cfg_data_i[R-1:0];
          mer_pkg::CFG_RADIUS_Y: ry_q <= cfg_data_i[R-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    a2_q    <= a2_d;
    b2_q    <= b2_d;
    dec_q   <= dec_d;
    acc_q   <= acc_d;
    slope_q <= slope_d;
    prod_q  <= prod_d;
    tdata_q <= tdata_d;
    last_q  <= last_d;
    user_q  <= user_d;
  end

  assign out_tdata_o = tdata_q;
  assign out_last_o  = last_q;
  assign out_user_o  = user_q;

endmodule

// ===== src/mer_checker.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module mer_checker #(
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [8*(COORD_BITS+1)-1:0]   m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only one transaction is in flight: the input closes after each one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // The closing point set always carries points.
  a_last_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last flagged on an empty result");

  // An empty result is all zeros.
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("empty result carries data");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker #(
  .COORD_BITS (COORD_BITS)
) u_mer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/ellipse_point_checker.sv =====
// ----------------------------------------------------------------------------
// Ellipse point-set checker
// Follows the configuration writes and the tick transactions that the
// rasterizer accepts, works out the mirrored point set that each tick should
// produce and compares every result transaction, field by field, against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ellipse_point_checker
  import mer_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [COORD_BITS_DEF-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // restart
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
  input  logic [8*(COORD_BITS_DEF+1)-1:0]    m_axis_tdata,
  input  logic                               m_axis_tlast,  // last
  input  logic                               m_axis_tuser,  // valid_res
  output int                                 error_count,
  output int                                 pending_count
);

  localparam int unsigned COORD_W = COORD_BITS_DEF + 1;
  localparam int unsigned RAD_W   = RADIUS_BITS_DEF;

  typedef struct packed {
    logic                      drawn;
    logic                      last;
    logic [7:0][COORD_W-1:0]   pts;  // same order as the output tdata
  } point_set_t;

  point_set_t expected_points_q[$];

  logic [COORD_BITS_DEF-1:0] centre_x_q, centre_y_q;
  logic [RAD_W-1:0]          radius_x_q, radius_y_q;
  logic [RAD_W-1:0]          off_x, off_y;
  logic [63:0]               decision_q, slope_q, rx_sq, ry_sq;
  logic                      region_two, walk_done;

  function automatic string coord_name(input int i);
    return $sformatf("pt%0d_%s", i / 2, (i % 2) ? "y" : "x");
  endfunction

  // Mirror the current first-quadrant offset around the live centre.
  task automatic queue_point_set();
    point_set_t ps;
    int         cx;
    int         cy;
    int         ox;
    int         oy;
    cx = int'($signed(centre_x_q));
    cy = int'($signed(centre_y_q));
    ox = int'(off_x);
    oy = int'(off_y);
    ps.drawn  = 1'b1;
    ps.last   = (off_y == '0);
    ps.pts[0] = COORD_W'(cx + ox);
    ps.pts[1] = COORD_W'(cy + oy);
    ps.pts[2] = COORD_W'(cx - ox);
    ps.pts[3] = COORD_W'(cy + oy);
    ps.pts[4] = COORD_W'(cx + ox);
    ps.pts[5] = COORD_W'(cy - oy);
    ps.pts[6] = COORD_W'(cx - ox);
    ps.pts[7] = COORD_W'(cy - oy);
    if (off_y == '0) walk_done = 1'b1;
    expected_points_q.push_back(ps);
  endtask

  // One tick of the walk. The decision variable is kept at four times its
  // real value in 64-bit wrap-around arithmetic, so its sign bit is exact.
  task automatic predict_tick(input logic restart_bit);
    logic [63:0] x, y, t, u;
    point_set_t  blank;
    if (restart_bit) begin
      rx_sq      = 64'(radius_x_q) * 64'(radius_x_q);
      ry_sq      = 64'(radius_y_q) * 64'(radius_y_q);
      off_x      = '0;
      off_y      = radius_y_q;
      slope_q    = 64'(0) - rx_sq * 64'(radius_y_q);
      decision_q = 4 * ry_sq - 4 * rx_sq * 64'(radius_y_q) + rx_sq;
      region_two = 1'b0;
      walk_done  = 1'b0;
      queue_point_set();
    end else if (walk_done) begin
      blank = '0;
      expected_points_q.push_back(blank);
    end else begin
      x = 64'(off_x);
      y = 64'(off_y);
      if (!region_two && slope_q[63]) begin
        if (decision_q[63]) begin
          decision_q = decision_q + 8 * ry_sq * x + 12 * ry_sq;
        end else begin
          decision_q = decision_q + 8 * ry_sq * x + 12 * ry_sq - 8 * rx_sq * y + 8 * rx_sq;
          y          = y - 1;
          slope_q    = slope_q + rx_sq;
        end
        x       = x + 1;
        slope_q = slope_q + ry_sq;
      end else begin
        // The tick that leaves region one seeds the region-two decision and
        // then takes a region-two step straight away.
        if (!region_two) begin
          t          = 2 * x + 1;
          u          = y - 1;
          decision_q = ry_sq * t * t + 4 * rx_sq * u * u - 4 * rx_sq * ry_sq;
          region_two = 1'b1;
        end
        if (!decision_q[63] && decision_q != 0) begin
          decision_q = decision_q + 12 * rx_sq - 8 * rx_sq * y;
        end else begin
          decision_q = decision_q + 8 * ry_sq * x + 8 * ry_sq - 8 * rx_sq * y + 12 * rx_sq;
          x          = x + 1;
        end
        y = y - 1;
      end
      off_x = x[RAD_W-1:0];
      off_y = y[RAD_W-1:0];
      queue_point_set();
    end
  endtask

  task automatic check_point_set();
    point_set_t          want;
    logic [COORD_W-1:0]  got;
    if (expected_points_q.size() == 0) begin
      $error("result transaction arrived with no point set expected");
      error_count++;
      return;
    end
    want = expected_points_q.pop_front();
    if (m_axis_tuser !== want.drawn) begin
      $error("valid_res: expected %0d, got %0d", want.drawn, m_axis_tuser);
      error_count++;
    end
    for (int i = 0; i < 8; i++) begin
      got = m_axis_tdata[i*COORD_W +: COORD_W];
      if (got !== want.pts[i]) begin
        $error("%s: expected %0d, got %0d", coord_name(i), $signed(want.pts[i]),
               $signed(got));
        error_count++;
      end
    end
    if (m_axis_tlast !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q  = '0;
      centre_y_q  = '0;
      radius_x_q  = RAD_W'(RADIUS_X_RST);
      radius_y_q  = RAD_W'(RADIUS_Y_RST);
      off_x       = '0;
      off_y       = '0;
      decision_q  = '0;
      slope_q     = '0;
      rx_sq       = '0;
      ry_sq       = '0;
      region_two  = 1'b0;
      walk_done   = 1'b1;
      error_count = 0;
      expected_points_q.delete();
    end else begin
      // A result can never belong to a tick accepted at the same edge, so
      // the comparison goes first.
      if (m_axis_tvalid && m_axis_tready) check_point_set();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X: centre_x_q = cfg_data_i;
          CFG_CENTER_Y: centre_y_q = cfg_data_i;
          CFG_RADIUS_X: radius_x_q = cfg_data_i[RAD_W-1:0];
          CFG_RADIUS_Y: radius_y_q = cfg_data_i[RAD_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata[0]);
    end
    pending_count = expected_points_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Drives configuration writes and restart/advance ticks into the rasterizer,
// first a short directed set around the corner cases, then randomised walks
// under bursty input and a stalling receiver. The point-set checker does the
// prediction and comparison; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mer_pkg::*;

  localparam int unsigned COORD_W      = COORD_BITS_DEF + 1;
  localparam int unsigned DATA_W       = 8 * COORD_W;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TICK_TARGET  = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 40;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i     = CFG_CENTER_X;
  logic [COORD_BITS_DEF-1:0] cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [DATA_W-1:0]         m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      m_axis_tuser;

  int error_count;
  int pending_count;
  int cycle_count = 0;
  int sent_ticks  = 0;
  int burst_left  = 0;
  bit hold_req    = 1'b0;
  int reg_rx      = RADIUS_X_RST;
  int reg_ry      = RADIUS_Y_RST;

  always #1 clk_i = ~clk_i;

  midpoint_ellipse_rasterizer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  ellipse_point_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value[COORD_BITS_DEF-1:0];
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    if (idx == CFG_RADIUS_X) reg_rx = value;
    if (idx == CFG_RADIUS_Y) reg_ry = value;
  endtask

  // Offers one tick; the sender works in bursts with idle gaps between them.
  task automatic send_tick(input bit restart_bit);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, restart_bit};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    sent_ticks++;
  endtask

  // Stops offering and waits until every predicted point set has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  function automatic int pick_radius();
    case ($urandom_range(0, 19))
      0:       return 1023;
      1:       return 0;
      2:       return $urandom_range(900, 1023);
      3, 4, 5: return $urandom_range(13, 60);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic int pick_centre();
    case ($urandom_range(0, 9))
      0:       return -2048;
      1:       return 2047;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // The receiver switches between randomly chosen stall patterns and, once
  // asked, holds off for a long stretch so that the block backs up.
  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = 1'($urandom_range(0, 1));
        2:       m_axis_tready = ($urandom_range(0, 4) != 0);
        default: m_axis_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    int  steps;
    bit  hold_done;
    hold_done = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Nothing has been started since reset, so this tick draws nothing.
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);

    // A flat ellipse: the very first point set is already the last one.
    drain();
    write_reg(CFG_RADIUS_Y, 0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Zero horizontal radius crosses into region two on the first step, and
    // the walk runs on past its end.
    drain();
    write_reg(CFG_RADIUS_X, 0);
    write_reg(CFG_RADIUS_Y, 3);
    write_reg(CFG_CENTER_X, -2048);
    write_reg(CFG_CENTER_Y, 2047);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);

    // Widest radii at the opposite corner of the plane.
    drain();
    write_reg(CFG_RADIUS_X, 1023);
    write_reg(CFG_RADIUS_Y, 1023);
    write_reg(CFG_CENTER_X, 2047);
    write_reg(CFG_CENTER_Y, -2048);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);

    // New radii wait for the next restart; a new centre applies at once.
    drain();
    write_reg(CFG_RADIUS_X, 6);
    write_reg(CFG_RADIUS_Y, 1);
    write_reg(CFG_CENTER_X, 100);
    write_reg(CFG_CENTER_Y, -100);
    repeat (2) send_tick(1'b0);

    // A low ellipse reaches y = 0 while still in region one.
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);

    while (sent_ticks < TICK_TARGET) begin
      drain();
      if ($urandom_range(0, 1)) write_reg(CFG_CENTER_X, pick_centre());
      if ($urandom_range(0, 1)) write_reg(CFG_CENTER_Y, pick_centre());
      if ($urandom_range(0, 1)) write_reg(CFG_RADIUS_X, pick_radius());
      if ($urandom_range(0, 1)) write_reg(CFG_RADIUS_Y, pick_radius());
      // Occasionally carry on the previous walk under the new settings.
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_tick(1'b0);
      repeat ($urandom_range(1, 3)) begin
        if (reg_rx > 60 || reg_ry > 60) begin
          steps = $urandom_range(1, 40);
        end else if ($urandom_range(0, 3) == 0) begin
          steps = $urandom_range(0, reg_rx + reg_ry + 2);
        end else begin
          steps = reg_rx + reg_ry + $urandom_range(1, 3);
        end
        send_tick(1'b1);
        repeat (steps) begin
          if (!hold_done && sent_ticks >= 150) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
          end
          // A stray restart now and then breaks the walk off early.
          send_tick($urandom_range(0, 24) == 0);
        end
      end
    end

    drain();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mer_pkg.sv
src/mer_ctrl.sv
src/mer_datapath.sv
src/midpoint_ellipse_rasterizer_top.sv
src/mer_checker.sv
dv/ellipse_point_checker.sv
dv/testbench.sv
